[rtl/spp_pkg.sv]
// Shared constants, register codes and stage payload types for the servo PID block.
// Used by every module and by both channel interfaces; depends on nothing.
package spp_pkg;

  localparam int COORD_BITS = 10;
  localparam int SUM_BITS = 24;

  localparam int GAIN_BITS = 16;
  localparam int GAIN_S_BITS = GAIN_BITS + 7;
  localparam int CFG_DATA_BITS = (COORD_BITS > GAIN_BITS) ? COORD_BITS : GAIN_BITS;
  localparam int CFG_INDEX_BITS = 2;

  localparam int ERR_BITS = COORD_BITS + 1;
  localparam int DIFF_BITS = COORD_BITS + 2;
  localparam int ACC_BITS = ((SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS) + 1;

  localparam int P_E_BITS = GAIN_S_BITS + ERR_BITS;
  localparam int P_I_BITS = GAIN_S_BITS + SUM_BITS;
  localparam int P_D_BITS = GAIN_BITS + DIFF_BITS;
  localparam int T_BITS = ((P_I_BITS > P_E_BITS) ? P_I_BITS : P_E_BITS) + 2;

  localparam int TENTH_SCALE = 256000;
  localparam int QUOT_SHIFT = 11;
  localparam int QIN_BITS = 16;
  localparam int RECIP_BITS = 17;
  localparam int RECIP_SHIFT = 23;
  localparam int Q_BITS = 10;
  localparam int DUTY_BITS = 10;
  localparam int CMP_BITS = 19;
  localparam int CMP_SHIFT = 7;

  localparam logic signed [GAIN_S_BITS-1:0] GAIN_SCALE = GAIN_S_BITS'(100);
  localparam logic [COORD_BITS-1:0] REFERENCE_RESET = COORD_BITS'(240);
  localparam logic signed [GAIN_S_BITS-1:0] KP_SCALED_RESET = GAIN_S_BITS'(25600);

  localparam logic signed [T_BITS-1:0] T_ZERO = '0;
  localparam logic signed [T_BITS-1:0] T_POS_MAX = T_BITS'(278 * TENTH_SCALE);
  localparam logic signed [T_BITS-1:0] T_POS_MIN = T_BITS'(5 * TENTH_SCALE);
  localparam logic signed [T_BITS-1:0] T_NEG_DEAD = T_BITS'(-TENTH_SCALE);
  localparam logic signed [T_BITS-1:0] T_NEG_MIN = T_BITS'(-278 * TENTH_SCALE);
  localparam logic signed [T_BITS-1:0] T_CEIL_BIAS = T_BITS'(TENTH_SCALE - 1);

  localparam logic [RECIP_BITS-1:0] RECIP_125 = RECIP_BITS'(67109);

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = DUTY_BITS'(1000);
  localparam logic [DUTY_BITS-1:0] DUTY_DEAD_POS = DUTY_BITS'(720);
  localparam logic [DUTY_BITS-1:0] DUTY_BASE_POS = DUTY_BITS'(722);
  localparam logic [DUTY_BITS-1:0] DUTY_BASE_NEG = DUTY_BITS'(671);
  localparam logic [DUTY_BITS-1:0] DUTY_DEAD_NEG = DUTY_BITS'(672);
  localparam logic [DUTY_BITS-1:0] DUTY_MIN = DUTY_BITS'(393);
  localparam logic [CMP_BITS-1:0] CMP_OFFSET = CMP_BITS'(128);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_REFERENCE,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D
  } reg_index_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] reference;
    logic signed [GAIN_S_BITS-1:0] kp_scaled;
    logic signed [GAIN_S_BITS-1:0] ki_scaled;
    logic signed [GAIN_BITS-1:0] kd;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_BITS-1:0] err;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [SUM_BITS-1:0] sum;
  } err_t;

  typedef struct packed {
    logic dir;
    logic fixed;
    logic [DUTY_BITS-1:0] fixed_duty;
    logic [QIN_BITS-1:0] quot_in;
  } map_t;

  typedef struct packed {
    logic direction;
    logic [DUTY_BITS-1:0] duty_value;
    logic [CMP_BITS-1:0] compare_word;
  } res_t;

endpackage

[rtl/spp_sample_if.sv]
// Valid/ready channel that carries one coordinate request into the block.
// Depends on spp_pkg for the coordinate width.
interface spp_sample_if;
  logic valid;
  logic ready;
  logic [spp_pkg::COORD_BITS-1:0] coordinate;

  modport source(output valid, output coordinate, input ready);
  modport sink(input valid, input coordinate, output ready);
endinterface

[rtl/spp_result_if.sv]
// Valid/ready channel that carries one duty result request out of the block.
// Depends on spp_pkg for the field widths.
interface spp_result_if;
  logic valid;
  logic ready;
  logic direction;
  logic [spp_pkg::DUTY_BITS-1:0] duty_value;
  logic [spp_pkg::CMP_BITS-1:0] compare_word;

  modport source(output valid, output direction, output duty_value, output compare_word,
                 input ready);
  modport sink(input valid, input direction, input duty_value, input compare_word,
               output ready);
endinterface

[rtl/spp_cfg.sv]
// Configuration register file: reference position and gains, the P and I gains
// stored premultiplied by 100. Depends on spp_pkg.
module spp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [spp_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [spp_pkg::CFG_DATA_BITS-1:0]   wr_data,
  output spp_pkg::cfg_t                       cfg
);

  logic signed [spp_pkg::GAIN_S_BITS-1:0] gain_ext;
  logic signed [spp_pkg::GAIN_S_BITS-1:0] gain_scaled;

  assign gain_ext = spp_pkg::GAIN_S_BITS'($signed(wr_data[spp_pkg::GAIN_BITS-1:0]));
  assign gain_scaled = gain_ext * spp_pkg::GAIN_SCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reference <= spp_pkg::REFERENCE_RESET;
      cfg.kp_scaled <= spp_pkg::KP_SCALED_RESET;
      cfg.ki_scaled <= '0;
      cfg.kd <= '0;
    end else if (wr_en) begin
      unique case (spp_pkg::reg_index_t'(wr_index))
        spp_pkg::REG_REFERENCE: cfg.reference <= wr_data[spp_pkg::COORD_BITS-1:0];
        spp_pkg::REG_GAIN_P: cfg.kp_scaled <= gain_scaled;
        spp_pkg::REG_GAIN_I: cfg.ki_scaled <= gain_scaled;
        spp_pkg::REG_GAIN_D: cfg.kd <= $signed(wr_data[spp_pkg::GAIN_BITS-1:0]);
        default: ;
      endcase
    end
  end

endmodule

[rtl/spp_error.sv]
// Error stage: forms the error and its difference, keeps the previous error and
// the saturating error sum, and registers them. Depends on spp_pkg.
module spp_error (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [spp_pkg::COORD_BITS-1:0]  coordinate,
  input  logic [spp_pkg::COORD_BITS-1:0]  reference,
  output spp_pkg::err_t                   stage
);

  logic signed [spp_pkg::ERR_BITS-1:0] prev_err;
  logic signed [spp_pkg::SUM_BITS-1:0] err_sum;
  logic signed [spp_pkg::SUM_BITS-1:0] err_sum_next;
  logic signed [spp_pkg::ERR_BITS-1:0] err;
  logic signed [spp_pkg::DIFF_BITS-1:0] diff;
  logic signed [spp_pkg::ACC_BITS-1:0] acc;
  logic [spp_pkg::ACC_BITS-spp_pkg::SUM_BITS:0] acc_top;

  always_comb begin
    err = $signed({1'b0, coordinate}) - $signed({1'b0, reference});
    diff = spp_pkg::DIFF_BITS'(err) - spp_pkg::DIFF_BITS'(prev_err);
    acc = spp_pkg::ACC_BITS'(err_sum) + spp_pkg::ACC_BITS'(err);
    acc_top = acc[spp_pkg::ACC_BITS-1:spp_pkg::SUM_BITS-1];
    if ((&acc_top) || !(|acc_top)) begin
      err_sum_next = acc[spp_pkg::SUM_BITS-1:0];
    end else begin
      err_sum_next = {acc[spp_pkg::ACC_BITS-1], {(spp_pkg::SUM_BITS-1){~acc[spp_pkg::ACC_BITS-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      err_sum <= '0;
    end else if (load) begin
      prev_err <= err;
      err_sum <= err_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.err <= err;
      stage.diff <= diff;
      stage.sum <= err_sum_next;
    end
  end

endmodule

[rtl/spp_gain.sv]
// Gain stages: three registered products, then their registered sum, which is
// 25600 times the PID value. Depends on spp_pkg.
module spp_gain (
  input  logic                               clk,
  input  logic [1:0]                         load,
  input  spp_pkg::cfg_t                      cfg,
  input  spp_pkg::err_t                      stage,
  output logic signed [spp_pkg::T_BITS-1:0]  total
);

  logic signed [spp_pkg::P_E_BITS-1:0] prod_e;
  logic signed [spp_pkg::P_I_BITS-1:0] prod_i;
  logic signed [spp_pkg::P_D_BITS-1:0] prod_d;
  logic signed [spp_pkg::P_E_BITS-1:0] prod_e_next;
  logic signed [spp_pkg::P_I_BITS-1:0] prod_i_next;
  logic signed [spp_pkg::P_D_BITS-1:0] prod_d_next;
  logic signed [spp_pkg::T_BITS-1:0] total_next;

  assign prod_e_next = cfg.kp_scaled * stage.err;
  assign prod_i_next = cfg.ki_scaled * stage.sum;
  assign prod_d_next = cfg.kd * stage.diff;
  assign total_next = spp_pkg::T_BITS'(prod_e) + spp_pkg::T_BITS'(prod_i)
                    + (spp_pkg::T_BITS'(prod_d) <<< 1);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      prod_e <= prod_e_next;
      prod_i <= prod_i_next;
      prod_d <= prod_d_next;
    end
    if (load[1]) begin
      total <= total_next;
    end
  end

endmodule

[rtl/spp_duty.sv]
// Duty stages: direction, clamp decision and divider operand, then the divide by
// 256000 through a reciprocal multiply, the duty and the compare word. Depends on spp_pkg.
module spp_duty (
  input  logic                               clk,
  input  logic [1:0]                         load,
  input  logic signed [spp_pkg::T_BITS-1:0]  total,
  output spp_pkg::res_t                      res
);

  spp_pkg::map_t map;
  spp_pkg::map_t map_next;
  logic signed [spp_pkg::T_BITS-1:0] div_src;
  logic [spp_pkg::QIN_BITS+spp_pkg::RECIP_BITS-1:0] prod;
  logic [spp_pkg::Q_BITS-1:0] quot;
  logic [spp_pkg::DUTY_BITS-1:0] duty;
  logic [spp_pkg::DUTY_BITS+2:0] duty_x5;
  logic [spp_pkg::DUTY_BITS+1:0] ticks;

  always_comb begin
    map_next.dir = total > spp_pkg::T_ZERO;
    map_next.fixed = 1'b0;
    map_next.fixed_duty = spp_pkg::DUTY_MAX;
    if (map_next.dir) begin
      if (total > spp_pkg::T_POS_MAX) begin
        map_next.fixed = 1'b1;
        map_next.fixed_duty = spp_pkg::DUTY_MAX;
      end else if (total < spp_pkg::T_POS_MIN) begin
        map_next.fixed = 1'b1;
        map_next.fixed_duty = spp_pkg::DUTY_DEAD_POS;
      end
      div_src = total;
    end else begin
      if (total > spp_pkg::T_NEG_DEAD) begin
        map_next.fixed = 1'b1;
        map_next.fixed_duty = spp_pkg::DUTY_DEAD_NEG;
      end else if (total < spp_pkg::T_NEG_MIN) begin
        map_next.fixed = 1'b1;
        map_next.fixed_duty = spp_pkg::DUTY_MIN;
      end
      div_src = spp_pkg::T_CEIL_BIAS - total;
    end
    map_next.quot_in = div_src[spp_pkg::QUOT_SHIFT+spp_pkg::QIN_BITS-1:spp_pkg::QUOT_SHIFT];
  end

  always_comb begin
    prod = map.quot_in * spp_pkg::RECIP_125;
    quot = prod[spp_pkg::RECIP_SHIFT+spp_pkg::Q_BITS-1:spp_pkg::RECIP_SHIFT];
    if (map.fixed) begin
      duty = map.fixed_duty;
    end else if (map.dir) begin
      duty = spp_pkg::DUTY_BASE_POS + quot;
    end else begin
      duty = spp_pkg::DUTY_BASE_NEG - quot;
    end
    duty_x5 = {1'b0, duty, 2'b00} + {3'b000, duty};
    ticks = duty_x5[spp_pkg::DUTY_BITS+2:1];
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      map <= map_next;
    end
    if (load[1]) begin
      res.direction <= map.dir;
      res.duty_value <= duty;
      res.compare_word <= {ticks, {spp_pkg::CMP_SHIFT{1'b0}}} + spp_pkg::CMP_OFFSET;
    end
  end

endmodule

[rtl/servo_pid_pwm_step.sv]
// Top level of the servo axis PID controller with duty and timer compare mapping.
// Depends on spp_pkg, spp_sample_if, spp_result_if, spp_cfg, spp_error, spp_gain, spp_duty.
//
// Usage: each request on the sample channel carries one measured coordinate; for
// each one, exactly one request leaves on the result channel with the direction,
// the clamped duty and the timer compare word, in order. Both channels use
// valid/ready and move a request at a clock edge where both are high.
// The gains and the reference are set through the write port (wr_en, wr_index,
// wr_data) while no request is in flight; a write takes effect for the next sample.
// Throughput: one sample per cycle while the result channel is ready; the five-register
// pipeline (error, products, sum, clamp decision, result) has each register doing one step.
// Each stage keeps its request when the next one is full, so a stalled receiver
// only blocks the input once all five stages hold a request; bubbles fill up first.
// Reset (rst, synchronous) empties the pipeline, clears the previous error and the
// error sum, and loads reference 240, proportional gain 1.0 and zero I and D gains.
module servo_pid_pwm_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [spp_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [spp_pkg::CFG_DATA_BITS-1:0]   wr_data,
  spp_sample_if.sink                          sample,
  spp_result_if.source                        result
);

  spp_pkg::cfg_t cfg;
  spp_pkg::err_t err_stage;
  spp_pkg::res_t res;
  logic signed [spp_pkg::T_BITS-1:0] total;

  logic [5:1] stage_valid;
  logic [5:1] stage_valid_next;
  logic [6:1] free;
  logic [5:1] load;

  always_comb begin
    free[6] = result.ready;
    for (int k = 5; k >= 1; k--) begin
      free[k] = !stage_valid[k] || free[k+1];
    end
    load[1] = sample.valid && free[1];
    stage_valid_next[1] = free[1] ? sample.valid : stage_valid[1];
    for (int k = 2; k <= 5; k++) begin
      load[k] = stage_valid[k-1] && free[k];
      stage_valid_next[k] = free[k] ? stage_valid[k-1] : stage_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  spp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  spp_error u_error (
    .clk        (clk),
    .rst        (rst),
    .load       (load[1]),
    .coordinate (sample.coordinate),
    .reference  (cfg.reference),
    .stage      (err_stage)
  );

  spp_gain u_gain (
    .clk   (clk),
    .load  (load[3:2]),
    .cfg   (cfg),
    .stage (err_stage),
    .total (total)
  );

  spp_duty u_duty (
    .clk   (clk),
    .load  (load[5:4]),
    .total (total),
    .res   (res)
  );

  assign sample.ready = free[1];
  assign result.valid = stage_valid[5];
  assign result.direction = res.direction;
  assign result.duty_value = res.duty_value;
  assign result.compare_word = res.compare_word;

  a_ready_with_room: assert property (@(posedge clk) disable iff (rst)
    !(&stage_valid) |-> sample.ready)
    else $error("sample not taken although a pipeline stage is empty");

  a_positive_duty_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.direction |->
      result.duty_value >= spp_pkg::DUTY_DEAD_POS && result.duty_value <= spp_pkg::DUTY_MAX)
    else $error("duty outside the positive range");

  a_negative_duty_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.direction |->
      result.duty_value >= spp_pkg::DUTY_MIN && result.duty_value <= spp_pkg::DUTY_DEAD_NEG)
    else $error("duty outside the negative range");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result.valid && stage_valid == '0)
    else $error("pipeline not empty after reset");

endmodule

[tb/tb_servo_pid_pwm_step.sv]
// Self-checking testbench for servo_pid_pwm_step: drives coordinate requests, predicts the
// direction, duty and compare word of each one and checks every result request in order.
// Depends on spp_pkg, spp_sample_if, spp_result_if and the servo_pid_pwm_step RTL.
`timescale 1ns / 1ps

module tb_servo_pid_pwm_step;

  localparam longint PID_TENTH = 256000;
  localparam longint SUM_MAX = (longint'(1) << (spp_pkg::SUM_BITS - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  logic wr_en;
  logic [spp_pkg::CFG_INDEX_BITS-1:0] wr_index;
  logic [spp_pkg::CFG_DATA_BITS-1:0] wr_data;

  spp_sample_if sample_ch();
  spp_result_if result_ch();

  servo_pid_pwm_step uut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .sample(sample_ch),
    .result(result_ch)
  );

  logic [spp_pkg::COORD_BITS-1:0] target_pos;
  logic signed [15:0] kp_gain;
  logic signed [15:0] ki_gain;
  logic signed [15:0] kd_gain;
  longint last_err;
  longint err_sum;

  spp_pkg::res_t duty_result_q[$];

  int src_idle_pct;
  int snk_idle_pct;
  int hold_request;
  int hold_left;
  int quiet_cycles;
  int fail_count;
  int items_sent;
  int results_seen;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic spp_pkg::res_t compute_duty_result(
      input logic [spp_pkg::COORD_BITS-1:0] coord);
    longint err;
    longint step;
    longint t;
    longint m;
    longint duty;
    spp_pkg::res_t r;
    err = longint'(coord) - longint'(target_pos);
    step = err - last_err;
    err_sum = err_sum + err;
    if (err_sum > SUM_MAX) err_sum = SUM_MAX;
    if (err_sum < SUM_MIN) err_sum = SUM_MIN;
    last_err = err;
    t = 100 * longint'(kp_gain) * err + 100 * longint'(ki_gain) * err_sum
      + 2 * longint'(kd_gain) * step;
    if (t > 0) begin
      r.direction = 1'b1;
      if (t > 278 * PID_TENTH) duty = 1000;
      else if (t < 5 * PID_TENTH) duty = 720;
      else duty = 722 + t / PID_TENTH;
    end else begin
      r.direction = 1'b0;
      m = -t;
      if (m < PID_TENTH) duty = 672;
      else if (m > 278 * PID_TENTH) duty = 393;
      else duty = 671 - (m + PID_TENTH - 1) / PID_TENTH;
    end
    r.duty_value = spp_pkg::DUTY_BITS'(duty);
    r.compare_word = spp_pkg::CMP_BITS'((((duty * 25000) / 10000) << 7) + 128);
    return r;
  endfunction

  function automatic logic [spp_pkg::COORD_BITS-1:0] pick_coordinate();
    int c;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4: begin
        c = int'(target_pos) + int'($urandom_range(64)) - 32;
        if (c < 0) c = 0;
        if (c > 1023) c = 1023;
        return spp_pkg::COORD_BITS'(c);
      end
      default: return spp_pkg::COORD_BITS'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain(input int span);
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      3: return 16'h0000;
      default: return 16'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  task automatic send_coordinate(input logic [spp_pkg::COORD_BITS-1:0] coord);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.coordinate <= coord;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    duty_result_q.push_back(compute_duty_result(coord));
    items_sent++;
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (duty_result_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input spp_pkg::reg_index_t idx, input logic [15:0] data);
    wait_idle();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      spp_pkg::REG_REFERENCE: target_pos = data[spp_pkg::COORD_BITS-1:0];
      spp_pkg::REG_GAIN_P: kp_gain = data;
      spp_pkg::REG_GAIN_I: ki_gain = data;
      spp_pkg::REG_GAIN_D: kd_gain = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_coordinate(10'd240);
    send_coordinate(10'd1023);
    send_coordinate(10'd0);
    send_coordinate(10'd245);
    send_coordinate(10'd290);
    send_coordinate(10'd239);
    send_coordinate(10'd230);
    send_coordinate(10'd1023);
  endtask

  task automatic test_duty_thresholds();
    write_reg(spp_pkg::REG_REFERENCE, 16'd0);
    write_reg(spp_pkg::REG_GAIN_P, 16'd1024);
    send_coordinate(10'd12);
    send_coordinate(10'd13);
    send_coordinate(10'd694);
    send_coordinate(10'd695);
    send_coordinate(10'd696);
    write_reg(spp_pkg::REG_REFERENCE, 16'd1023);
    send_coordinate(10'd1022);
    send_coordinate(10'd1020);
    send_coordinate(10'd328);
    send_coordinate(10'd327);
  endtask

  // The reference is written with its unused upper bits set, and it is moved between
  // requests so that the derivative sees the widest possible error step.
  task automatic test_gain_extremes();
    write_reg(spp_pkg::REG_REFERENCE, 16'hFC00);
    write_reg(spp_pkg::REG_GAIN_P, 16'h7FFF);
    send_coordinate(10'd1023);
    write_reg(spp_pkg::REG_GAIN_P, 16'h8000);
    send_coordinate(10'd1023);
    write_reg(spp_pkg::REG_GAIN_P, 16'h0000);
    write_reg(spp_pkg::REG_GAIN_D, 16'h7FFF);
    send_coordinate(10'd0);
    send_coordinate(10'd1023);
    write_reg(spp_pkg::REG_REFERENCE, 16'hFFFF);
    send_coordinate(10'd0);
    write_reg(spp_pkg::REG_REFERENCE, 16'hFC00);
    send_coordinate(10'd1023);
    write_reg(spp_pkg::REG_GAIN_D, 16'h8000);
    send_coordinate(10'd0);
    write_reg(spp_pkg::REG_GAIN_D, 16'h0000);
    write_reg(spp_pkg::REG_GAIN_I, 16'h7FFF);
    send_coordinate(10'd512);
    write_reg(spp_pkg::REG_GAIN_I, 16'h8000);
    send_coordinate(10'd512);
  endtask

  // With only the integral gain active the error sum is swept in small steps through
  // the whole unclamped range into both duty limits and back.
  task automatic test_integral_sweep();
    write_reg(spp_pkg::REG_GAIN_P, 16'd0);
    write_reg(spp_pkg::REG_GAIN_D, 16'd0);
    write_reg(spp_pkg::REG_GAIN_I, 16'd64);
    write_reg(spp_pkg::REG_REFERENCE, 16'd0);
    while (err_sum < 12000) send_coordinate(10'd200);
    write_reg(spp_pkg::REG_REFERENCE, 16'd200);
    while (err_sum > -12000) send_coordinate(10'd0);
    write_reg(spp_pkg::REG_REFERENCE, 16'd0);
    while (err_sum < 0) send_coordinate(10'd200);
  endtask

  task automatic test_backpressure();
    write_reg(spp_pkg::REG_REFERENCE, 16'd512);
    write_reg(spp_pkg::REG_GAIN_P, 16'd200);
    write_reg(spp_pkg::REG_GAIN_I, 16'd0);
    write_reg(spp_pkg::REG_GAIN_D, 16'd300);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 80;
    repeat (30) send_coordinate(pick_coordinate());
  endtask

  task automatic test_random_traffic();
    logic [15:0] ref_word;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 31;
          snk_idle_pct = 63;
        end
        1: begin
          src_idle_pct = 63;
          snk_idle_pct = 31;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        ref_word = 16'($urandom);
        if ($urandom_range(3) == 0) ref_word[9:0] = $urandom_range(1) ? 10'h3FF : 10'h000;
        write_reg(spp_pkg::REG_REFERENCE, ref_word);
        write_reg(spp_pkg::REG_GAIN_P, pick_gain(1024));
        write_reg(spp_pkg::REG_GAIN_I, pick_gain(4));
        write_reg(spp_pkg::REG_GAIN_D, pick_gain(4096));
        repeat (80) send_coordinate(pick_coordinate());
      end
    end
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    spp_pkg::res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (duty_result_q.size() == 0) begin
        $display("%0t: unexpected result request dir=%0d duty=%0d cmp=%0d", $time,
                 result_ch.direction, result_ch.duty_value, result_ch.compare_word);
        fail_count++;
      end else begin
        want = duty_result_q.pop_front();
        if (result_ch.direction !== want.direction) begin
          $display("%0t: direction expected %0d actual %0d", $time, want.direction,
                   result_ch.direction);
          fail_count++;
        end
        if (result_ch.duty_value !== want.duty_value) begin
          $display("%0t: duty_value expected %0d actual %0d", $time, want.duty_value,
                   result_ch.duty_value);
          fail_count++;
        end
        if (result_ch.compare_word !== want.compare_word) begin
          $display("%0t: compare_word expected %0d actual %0d", $time, want.compare_word,
                   result_ch.compare_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    target_pos = 10'd240;
    kp_gain = 16'sd256;
    ki_gain = 16'sd0;
    kd_gain = 16'sd0;
    last_err = 0;
    err_sum = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.coordinate <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_duty_thresholds();
    test_gain_extremes();
    test_integral_sweep();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (8) @(posedge clk);
    if (duty_result_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, duty_result_q.size());
      fail_count++;
    end
    $display("Checked %0d duty results from %0d coordinate requests and %0d register writes,",
             results_seen, items_sent, reg_writes);
    $display("covering duty thresholds, gain extremes, integral sweeps and output stalls.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
